[src/tes_pkg.sv]
`timescale 1ns / 1ps

package tes_pkg;

  // Series length limit and the widths that follow from it.
  localparam int MAX_TERMS = 32;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int DIV_W     = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;

  // Fixed-point formats of the channels and the configuration register.
  localparam int FRAC_W = 16;
  localparam int X_W    = 21;
  localparam int SUM_W  = 41;
  localparam int CFG_W  = 6;

  // Term magnitude, product and accumulator widths.
  localparam int XMAG_W = X_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = MAG_W + XMAG_W;
  localparam int NUM_W  = PROD_W + 1 - FRAC_W;
  localparam int ACC_W  = MAG_W + CNT_W + 1;

  // Digit-serial divider by the term index: radix 16.
  localparam int DIGIT_W   = 4;
  localparam int RADIX     = 1 << DIGIT_W;
  localparam int NDIG      = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIVD_W    = NDIG * DIGIT_W;
  localparam int DIG_CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int V_W       = DIV_W + DIGIT_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_item;
    logic             acc;
    logic             mul;
    logic             div_load;
    logic             div_step;
    logic             clip;
    logic             load_out;
    logic [CNT_W-1:0] term_idx;
  } tes_cmd_t;

endpackage

[src/tes_in_if.sv]
`timescale 1ns / 1ps

interface tes_in_if;
  import tes_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

[src/tes_out_if.sv]
`timescale 1ns / 1ps

interface tes_out_if;
  import tes_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] series_sum;
  logic                    saturated;

  modport source (output valid, output series_sum, output saturated, input ready);
  modport sink (input valid, input series_sum, input saturated, output ready);
endinterface

[src/tes_datapath.sv]
`timescale 1ns / 1ps

module tes_datapath (
  input  logic                           clk,
  input  logic signed [tes_pkg::X_W-1:0] x_value,
  input  tes_pkg::tes_cmd_t              cmd,
  output logic signed [tes_pkg::SUM_W-1:0] series_sum,
  output logic                           saturated
);
  import tes_pkg::*;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic signed [ACC_W-1:0] SUM_HI =
    {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_LO =
    {{(ACC_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

  logic                    x_neg_r;
  logic [XMAG_W-1:0]       x_mag_r;
  logic [MAG_W-1:0]        mag_r;
  logic signed [ACC_W-1:0] sum_r;
  logic                    sat_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIVD_W-1:0]       dvd_r;
  logic [DIVD_W-1:0]       quo_r;
  logic [DIV_W-1:0]        rem_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_sat_r;

  logic [DIV_W-1:0]        divisor;
  logic [XMAG_W-1:0]       x_abs;
  logic [PROD_W:0]         num;
  logic [V_W-1:0]          step_v;
  logic [DIGIT_W-1:0]      qd;
  logic [V_W-1:0]          step_rem;
  logic signed [ACC_W-1:0] mag_ext;

  assign divisor = cmd.term_idx[DIV_W-1:0];
  assign x_abs   = x_value[X_W-1] ? (~x_value + XMAG_W'(1)) : x_value;
  assign mag_ext = $signed({{(ACC_W - MAG_W){1'b0}}, mag_r});

  // Rounding bias of half the divisor, then drop the fraction scale.
  assign num = {1'b0, prod_r} + ((PROD_W + 1)'(divisor) << (FRAC_W - 1));

  // One quotient digit per step: largest multiple of the divisor that fits.
  always_comb begin
    step_v = {rem_r, dvd_r[DIVD_W-1 -: DIGIT_W]};
    qd     = '0;
    for (int k = 1; k < RADIX; k++) begin
      if (step_v >= V_W'(k) * V_W'(divisor)) begin
        qd = DIGIT_W'(k);
      end
    end
    step_rem = step_v - V_W'(qd) * V_W'(divisor);
  end

  // Term recurrence, division and accumulation registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_neg_r <= x_value[X_W-1];
      x_mag_r <= x_abs;
      mag_r   <= MAG_W'(1) << FRAC_W;
      sum_r   <= '0;
      sat_r   <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(x_mag_r);
    end
    if (cmd.div_load) begin
      dvd_r <= DIVD_W'(num[PROD_W:FRAC_W]);
      quo_r <= '0;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_r << DIGIT_W;
      quo_r <= {quo_r[DIVD_W-DIGIT_W-1:0], qd};
      rem_r <= step_rem[DIV_W-1:0];
    end
    if (cmd.clip) begin
      if (quo_r > DIVD_W'(MAG_MAX)) begin
        mag_r <= MAG_MAX;
        sat_r <= 1'b1;
      end else begin
        mag_r <= quo_r[MAG_W-1:0];
      end
    end
    if (cmd.acc) begin
      // Odd terms of a negative argument are subtracted.
      if (x_neg_r && cmd.term_idx[0]) begin
        sum_r <= sum_r - mag_ext;
      end else begin
        sum_r <= sum_r + mag_ext;
      end
    end
  end

  // Output register with the final range clip.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sum_r > SUM_HI) begin
        out_sum_r <= SUM_HI[SUM_W-1:0];
        out_sat_r <= 1'b1;
      end else if (sum_r < SUM_LO) begin
        out_sum_r <= SUM_LO[SUM_W-1:0];
        out_sat_r <= 1'b1;
      end else begin
        out_sum_r <= sum_r[SUM_W-1:0];
        out_sat_r <= sat_r;
      end
    end
  end

  assign series_sum = out_sum_r;
  assign saturated  = out_sat_r;

endmodule

[src/tes_ctrl.sv]
`timescale 1ns / 1ps

module tes_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tes_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tes_pkg::tes_cmd_t         cmd
);
  import tes_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CLIP   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     term_count_r;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     term_idx_r, term_idx_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     idx_inc;

  // Counts above the limit run the full series.
  always_comb begin
    if (32'(term_count_r) > MAX_TERMS) begin
      n_eff = CNT_W'(MAX_TERMS);
    end else begin
      n_eff = CNT_W'(term_count_r);
    end
  end

  assign idx_inc = term_idx_r + CNT_W'(1);

  // Sequencer: per term multiply, round, divide digit by digit, clip, add.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    term_idx_nxt  = term_idx_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.term_idx  = term_idx_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          n_nxt         = n_eff;
          term_idx_nxt  = '0;
          state_nxt     = (n_eff == '0) ? S_FINISH : S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (idx_inc == n_r) begin
          state_nxt = S_FINISH;
        end else begin
          term_idx_nxt = idx_inc;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        dig_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dig_cnt_r == DIG_CNT_W'(NDIG - 1)) begin
          dig_cnt_nxt = '0;
          state_nxt   = S_CLIP;
        end else begin
          dig_cnt_nxt = dig_cnt_r + DIG_CNT_W'(1);
        end
      end
      S_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = S_ACC;
      end
      S_FINISH: begin
        // Wait here while the output register still holds an untaken result.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      term_idx_r  <= '0;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      term_idx_r  <= term_idx_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Term count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
    end else if (cfg_wr_en) begin
      term_count_r <= cfg_wr_data;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_empty_series: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && n_eff == '0) |=> state_r == S_FINISH)
    else $error("empty series did not go straight to finish");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> term_idx_r < n_r)
    else $error("term index beyond latched term count");

  a_digit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_DIV |-> dig_cnt_r == '0)
    else $error("digit counter left nonzero outside division");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> term_idx_r != '0)
    else $error("division by a zero term index");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result appeared without a finish step");
`endif

endmodule

[src/truncated_exp_series_unit.sv]
`timescale 1ns / 1ps

// Truncated exponential series unit.
// The input channel in_ch carries one signed Q4.16 argument x_value per
// transaction; the result channel out_ch returns one transaction with the
// signed Q24.16 sum of x^i/i! for i below the term count, and a saturated
// flag set when a term or the sum was clipped to range.
// The term count is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the unit is idle; the unit itself does not enforce
// this. Counts above 32 run 32 terms, a count of 0 returns 0.
// One item is worked at a time. Each term after the first takes a multiply
// by |x|, a rounding add, 12 radix-16 steps of the divider by the term
// index, a clip and an accumulate.
// The finished result sits in an output register, so the next item is
// accepted while it waits; if the receiver still stalls when that next item
// finishes, the unit holds in its finish step until the register drains.
// Synchronous reset clears the term count to 0 and empties the unit.
module truncated_exp_series_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tes_pkg::CFG_W-1:0] cfg_wr_data,
  tes_in_if.sink                    in_ch,
  tes_out_if.source                 out_ch
);
  import tes_pkg::*;

  tes_cmd_t cmd;

  tes_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd)
  );

  tes_datapath u_datapath (
    .clk        (clk),
    .x_value    (in_ch.x_value),
    .cmd        (cmd),
    .series_sum (out_ch.series_sum),
    .saturated  (out_ch.saturated)
  );

endmodule
